>>> rtl/half_step_stepper_move_sequencer_top_assert.svh
// ----------------------------------------------------------------------------
// Half-step stepper sequencer assertion macros
// Shared forms for the concurrent assertions of the sequencer checker.
// ----------------------------------------------------------------------------
`ifndef HALF_STEP_STEPPER_MOVE_SEQUENCER_TOP_ASSERT_SVH
`define HALF_STEP_STEPPER_MOVE_SEQUENCER_TOP_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define HSS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define HSS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/hss_pkg.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer package
// Operation codes, item types, constants and the half-step coil table.
// ----------------------------------------------------------------------------
package hss_pkg;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_TICK       = 2'd0;
    localparam opcode_t OP_MOVE_STEPS = 2'd1;
    localparam opcode_t OP_MOVE_ANGLE = 2'd2;
    localparam opcode_t OP_STOP       = 2'd3;

    localparam int          ADDR_W              = 2;
    localparam logic [1:0]  ADDR_STEPS_PER_REV  = 2'd0;
    localparam logic [15:0] STEPS_PER_REV_RESET = 16'd4096;

    localparam logic [30:0] STEPS_MAX = 31'h7FFF_FFFF;

    // Division by 360 is a shift by three and a division by 45. The
    // reciprocal is floor(2^28 / 45), which undershoots by at most one.
    localparam int          RECIP_SHIFT = 28;
    localparam logic [22:0] RECIP_45    = 23'd5965232;
    localparam logic [27:0] DIVISOR_45  = 28'd45;

    typedef struct packed {
        opcode_t            op;
        logic signed [31:0] step_count;
        logic signed [15:0] angle_deg;
        logic [15:0]        step_period;
    } in_item_t;

    typedef struct packed {
        opcode_t     op;
        logic        neg;
        logic [30:0] mag;
        logic [15:0] period;
    } move_cmd_t;

    typedef struct packed {
        logic adv2;
        logic adv3;
        logic adv4;
    } pipe_ctl_t;

    typedef struct packed {
        logic advance;
        logic valid;
    } core_ctl_t;

    function automatic logic [3:0] coil_lookup(input logic [2:0] phase);
        logic [3:0] pattern;
        case (phase)
            3'd0:    pattern = 4'h1;
            3'd1:    pattern = 4'h3;
            3'd2:    pattern = 4'h2;
            3'd3:    pattern = 4'h6;
            3'd4:    pattern = 4'h4;
            3'd5:    pattern = 4'hC;
            3'd6:    pattern = 4'h8;
            3'd7:    pattern = 4'h9;
            default: pattern = 4'h0;
        endcase
        return pattern;
    endfunction

endpackage

>>> rtl/half_step_stepper_move_sequencer_top.sv
// ----------------------------------------------------------------------------
// Half-step stepper move sequencer
// Items pass item_reg, the s2 and s3 stages, cmd_reg and the core result register.
// Throughput: one item per cycle unless m_ready stalls the five registers.
// The output register holds a waiting result while earlier stages still fill.
// Reset is synchronous and active low: the pipeline empties, the motion state
// clears with all coils released, and steps_per_rev returns to 4096.
// ----------------------------------------------------------------------------
module half_step_stepper_move_sequencer_top
    import hss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic signed [31:0] s_step_count,
    input  logic signed [15:0] s_angle_deg,
    input  logic [15:0]        s_step_period,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_coils,
    output logic               m_running,
    output logic               m_stepped
);

    logic [15:0] spr_reg;
    in_item_t    item_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        adv_out, adv1;
    pipe_ctl_t   pipe_ctl;
    core_ctl_t   core_ctl;
    move_cmd_t   cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_STEPS_PER_REV) ? {16'd0, spr_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spr_reg <= STEPS_PER_REV_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr == ADDR_STEPS_PER_REV)) begin
            spr_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        adv_out       = !m_valid || m_ready;
        pipe_ctl.adv4 = !v4_reg || adv_out;
        pipe_ctl.adv3 = !v3_reg || pipe_ctl.adv4;
        pipe_ctl.adv2 = !v2_reg || pipe_ctl.adv3;
        adv1          = !v1_reg || pipe_ctl.adv2;
        core_ctl.advance = adv_out;
        core_ctl.valid   = v4_reg;
    end

    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (pipe_ctl.adv2) begin
                v2_reg <= v1_reg;
            end
            if (pipe_ctl.adv3) begin
                v3_reg <= v2_reg;
            end
            if (pipe_ctl.adv4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            item_reg.op          <= s_opcode;
            item_reg.step_count  <= s_step_count;
            item_reg.angle_deg   <= s_angle_deg;
            item_reg.step_period <= s_step_period;
        end
    end

    hss_convert u_convert (
        .aclk          (aclk),
        .ctl           (pipe_ctl),
        .item          (item_reg),
        .steps_per_rev (spr_reg),
        .cmd           (cmd)
    );

    hss_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (core_ctl),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_coils   (m_coils),
        .m_running (m_running),
        .m_stepped (m_stepped)
    );

endmodule

>>> rtl/hss_convert.sv
// ----------------------------------------------------------------------------
// Half-step stepper move converter
// Three pipeline stages that turn an item into a move command: step count
// magnitude and angle product, reciprocal division by 360, and correction.
// ----------------------------------------------------------------------------
module hss_convert
    import hss_pkg::*;
(
    input  logic        aclk,
    input  pipe_ctl_t   ctl,
    input  in_item_t    item,
    input  logic [15:0] steps_per_rev,
    output move_cmd_t   cmd
);

    logic [31:0] cnt_mag;
    logic [30:0] cnt_sat;
    logic [15:0] ang_mag;
    logic        item_neg;
    logic [31:0] prod;

    opcode_t     s2_op_reg;
    logic        s2_neg_reg;
    logic [30:0] s2_mag_reg;
    logic [15:0] s2_period_reg;
    logic [31:0] s2_prod_reg;

    logic [27:0] x_val;
    logic [50:0] recip_prod;

    opcode_t     s3_op_reg;
    logic        s3_neg_reg;
    logic [30:0] s3_mag_reg;
    logic [15:0] s3_period_reg;
    logic [27:0] s3_x_reg;
    logic [22:0] s3_q0_reg;

    logic [27:0] rem;
    logic [22:0] quot;

    move_cmd_t   cmd_reg;
    move_cmd_t   cmd_next;

    always_comb begin
        cnt_mag  = item.step_count[31] ? (32'd0 - item.step_count) : item.step_count;
        cnt_sat  = cnt_mag[31] ? STEPS_MAX : cnt_mag[30:0];
        ang_mag  = item.angle_deg[15] ? (16'd0 - item.angle_deg) : item.angle_deg;
        item_neg = (item.op == OP_MOVE_STEPS) ? item.step_count[31] : item.angle_deg[15];
        prod     = ang_mag * steps_per_rev;
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv2) begin
            s2_op_reg     <= item.op;
            s2_neg_reg    <= item_neg;
            s2_mag_reg    <= cnt_sat;
            s2_period_reg <= item.step_period;
            s2_prod_reg   <= prod;
        end
    end

    always_comb begin
        x_val      = s2_prod_reg[30:3];
        recip_prod = {23'd0, x_val} * {28'd0, RECIP_45};
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv3) begin
            s3_op_reg     <= s2_op_reg;
            s3_neg_reg    <= s2_neg_reg;
            s3_mag_reg    <= s2_mag_reg;
            s3_period_reg <= s2_period_reg;
            s3_x_reg      <= x_val;
            s3_q0_reg     <= recip_prod[RECIP_SHIFT +: 23];
        end
    end

    always_comb begin
        rem             = s3_x_reg - ({5'd0, s3_q0_reg} * DIVISOR_45);
        quot            = s3_q0_reg + {22'd0, (rem >= DIVISOR_45)};
        cmd_next.op     = s3_op_reg;
        cmd_next.neg    = s3_neg_reg;
        cmd_next.period = s3_period_reg;
        cmd_next.mag    = (s3_op_reg == OP_MOVE_ANGLE) ? {8'd0, quot} : s3_mag_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv4) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd = cmd_reg;

endmodule

>>> rtl/hss_core.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer core
// Holds the motion state, applies one move command per cycle while the output
// advances, and registers the result item.
// ----------------------------------------------------------------------------
module hss_core
    import hss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  core_ctl_t  ctl,
    input  move_cmd_t  cmd,
    output logic       m_valid,
    output logic [3:0] m_coils,
    output logic       m_running,
    output logic       m_stepped
);

    logic [2:0]  phase_reg,   phase_next;
    logic [30:0] steps_reg,   steps_next;
    logic        ccw_reg,     ccw_next;
    logic [15:0] reload_reg,  reload_next;
    logic [15:0] delay_reg,   delay_next;
    logic [3:0]  coil_reg,    coil_next;
    logic        stepped_reg, stepped_next;
    logic        valid_reg;

    logic [15:0] delay_dec;
    logic [30:0] steps_dec;
    logic [2:0]  phase_step;
    logic [15:0] period_eff;

    always_comb begin
        delay_dec    = delay_reg - 16'd1;
        steps_dec    = steps_reg - 31'd1;
        phase_step   = ccw_reg ? (phase_reg - 3'd1) : (phase_reg + 3'd1);
        period_eff   = (cmd.period == 16'd0) ? 16'd1 : cmd.period;
        phase_next   = phase_reg;
        steps_next   = steps_reg;
        ccw_next     = ccw_reg;
        reload_next  = reload_reg;
        delay_next   = delay_reg;
        coil_next    = coil_reg;
        stepped_next = 1'b0;
        case (cmd.op)
            OP_TICK: begin
                if (steps_reg != 31'd0) begin
                    delay_next = delay_dec;
                    if (delay_dec == 16'd0) begin
                        phase_next   = phase_step;
                        coil_next    = coil_lookup(phase_step);
                        stepped_next = 1'b1;
                        steps_next   = steps_dec;
                        if (steps_dec == 31'd0) begin
                            ccw_next   = 1'b0;
                            delay_next = 16'd0;
                            coil_next  = 4'h0;
                        end else begin
                            delay_next = reload_reg;
                        end
                    end
                end
            end
            OP_MOVE_STEPS, OP_MOVE_ANGLE: begin
                if (cmd.mag != 31'd0) begin
                    steps_next  = cmd.mag;
                    ccw_next    = cmd.neg;
                    reload_next = period_eff;
                    delay_next  = period_eff;
                end
            end
            OP_STOP: begin
                steps_next = 31'd0;
                ccw_next   = 1'b0;
                delay_next = 16'd0;
                coil_next  = 4'h0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 3'd0;
            steps_reg   <= 31'd0;
            ccw_reg     <= 1'b0;
            reload_reg  <= 16'd0;
            delay_reg   <= 16'd0;
            coil_reg    <= 4'h0;
            stepped_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end else if (ctl.advance) begin
            valid_reg <= ctl.valid;
            if (ctl.valid) begin
                phase_reg   <= phase_next;
                steps_reg   <= steps_next;
                ccw_reg     <= ccw_next;
                reload_reg  <= reload_next;
                delay_reg   <= delay_next;
                coil_reg    <= coil_next;
                stepped_reg <= stepped_next;
            end
        end
    end

    assign m_valid   = valid_reg;
    assign m_coils   = coil_reg;
    assign m_running = (steps_reg != 31'd0);
    assign m_stepped = stepped_reg;

endmodule

>>> rtl/hss_checker.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer checker
// Port-level assertions on the result items of the sequencer top level.
// ----------------------------------------------------------------------------
`include "half_step_stepper_move_sequencer_top_assert.svh"

module hss_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic [3:0] m_coils,
    input logic       m_running,
    input logic       m_stepped
);

    `HSS_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid, "result valid after reset")

    `HSS_ASSERT(a_step_pattern, m_valid && m_stepped && m_running |-> ($countones(m_coils) == 1 || $countones(m_coils) == 2), "stepped item shows no half-step pattern")

    `HSS_ASSERT(a_last_step_release, m_valid && m_stepped && !m_running |-> m_coils == 4'h0, "coils held after the last step")

    `HSS_ASSERT(a_legal_pattern, m_valid |-> ($countones(m_coils) <= 2 && m_coils != 4'h5 && m_coils != 4'hA), "coil pattern outside the half-step sequence")

endmodule

bind half_step_stepper_move_sequencer_top hss_checker u_hss_checker (.*);
